// ===== src/rffp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rffp_pkg
// Shared types, sizes, codes and helpers of the first-fit rectangle placer.
// ----------------------------------------------------------------------------
package rffp_pkg;

	localparam int MAX_COLS = 8;
	localparam int MAX_ROWS = 8;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int SIZE_W   = 4;
	localparam int DIM_W    = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FABRIC_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FABRIC_ROWS = 2'd1;

	typedef enum logic [1:0] {
		ST_PLACED     = 2'd0,
		ST_NO_FIT     = 2'd1,
		ST_BAD_CORNER = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_CHECK,
		S_EVAL,
		S_MARK,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic row_begin;
		logic check_step;
		logic next_row;
		logic hit;
		logic mark_step;
		logic set_fail;
		logic set_ok;
		logic out_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic row_oob;
		logic last_k;
		logic found;
		logic is_place;
	} dp_status_t;

	// Mask of w columns starting at column x.
	function automatic logic [MAX_COLS-1:0] col_span(input logic [COL_W-1:0] x,
			input logic [SIZE_W-1:0] w);
		logic [2*MAX_COLS-1:0] m;
		m = ((2*MAX_COLS)'(1) << w) - (2*MAX_COLS)'(1);
		m = m << x;
		return m[MAX_COLS-1:0];
	endfunction

endpackage

// ===== src/rect_first_fit_placer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_first_fit_placer
// Rectangle placer on a tile fabric of up to 8 by 8 tiles, by first fit or
// at a requested corner, with an occupancy bitmap kept across requests.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and answers each with exactly
// one result word. For every candidate corner row the bitmap rows under the
// rectangle are read one per cycle and ORed together, after which all column
// positions of that row are tested at once and the lowest free one wins. A
// request is taken, then each corner row scanned passes through a row
// check, the row reads and an evaluation; the tiles are then marked one
// row per step and the result is posted. The rows are read in turn through
// the single read port of the bitmap. An explicit placement tests only its
// one row. The result
// sits in an output register, so a new request is taken while the previous
// result waits, and the block stalls only when a second result is ready
// before the first was taken. Configuration writes are always accepted and
// should be issued only while no request is in flight.
// ----------------------------------------------------------------------------
module rect_first_fit_placer (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,  // clear_grid[0], rect_width[4:1],
	                                                      // rect_height[8:5], want_col[11:9],
	                                                      // want_row[14:12], zero[15]
	input  logic                           s_axis_tuser,  // command[0]
	// Result stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // status[1:0], place_col[4:2],
	                                                      // place_row[7:5]
	// Register writes: index 0 is fabric_cols, index 1 is fabric_rows.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rffp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rffp_pkg::DIM_W-1:0]     cfg_data
);

	rffp_pkg::ctrl_cmd_t  cmd;
	rffp_pkg::dp_status_t sts;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	rffp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	rffp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tdata (s_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

// ===== src/rffp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rffp_datapath
// Occupancy bitmap, request registers, row accumulator and column fit logic.
// ----------------------------------------------------------------------------
module rffp_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rffp_pkg::ctrl_cmd_t             cmd,
	output rffp_pkg::dp_status_t            sts,
	input  logic                            s_axis_tuser,
	input  logic [15:0]                     s_axis_tdata,
	input  logic                            cfg_valid,
	input  logic [rffp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rffp_pkg::DIM_W-1:0]      cfg_data,
	output logic [7:0]                      m_axis_tdata
);

	logic [rffp_pkg::DIM_W-1:0]    fabric_cols_q;
	logic [rffp_pkg::DIM_W-1:0]    fabric_rows_q;
	logic [rffp_pkg::MAX_COLS-1:0] occ_q [rffp_pkg::MAX_ROWS];

	logic                          is_place_q;
	logic [rffp_pkg::SIZE_W-1:0]   w_q;
	logic [rffp_pkg::SIZE_W-1:0]   h_q;
	logic [rffp_pkg::COL_W-1:0]    wc_q;
	logic [rffp_pkg::SIZE_W-1:0]   y_q;
	logic [rffp_pkg::SIZE_W-1:0]   k_q;
	logic [rffp_pkg::MAX_COLS-1:0] acc_q;
	logic [rffp_pkg::COL_W-1:0]    res_col_q;
	rffp_pkg::status_t             res_status_q;
	logic [rffp_pkg::ROW_W-1:0]    res_row_q;
	logic [7:0]                    out_q;

	logic [rffp_pkg::DIM_W-1:0]    eff_cols;
	logic [rffp_pkg::DIM_W-1:0]    eff_rows;
	logic [rffp_pkg::SIZE_W-1:0]   row_addr;
	logic [rffp_pkg::MAX_COLS-1:0] rd_row;
	logic [rffp_pkg::MAX_COLS-1:0] col_fit;
	logic                          ff_found;
	logic [rffp_pkg::COL_W-1:0]    ff_col;

	assign eff_cols = (fabric_cols_q > rffp_pkg::DIM_W'(rffp_pkg::MAX_COLS)) ?
		rffp_pkg::DIM_W'(rffp_pkg::MAX_COLS) : fabric_cols_q;
	assign eff_rows = (fabric_rows_q > rffp_pkg::DIM_W'(rffp_pkg::MAX_ROWS)) ?
		rffp_pkg::DIM_W'(rffp_pkg::MAX_ROWS) : fabric_rows_q;

	assign row_addr = y_q + k_q;
	assign rd_row   = occ_q[row_addr[rffp_pkg::ROW_W-1:0]];

	// Candidate corners of the current row, each column on its own.
	always_comb begin
		for (int x = 0; x < rffp_pkg::MAX_COLS; x++) begin
			col_fit[x] = (w_q != '0) &&
				((rffp_pkg::SIZE_W+1)'(x) + (rffp_pkg::SIZE_W+1)'(w_q) <=
				 (rffp_pkg::SIZE_W+1)'(eff_cols)) &&
				((acc_q & rffp_pkg::col_span(rffp_pkg::COL_W'(x), w_q)) == '0);
		end
	end

	// Lowest fitting column wins.
	always_comb begin
		ff_found = 1'b0;
		ff_col   = '0;
		for (int x = rffp_pkg::MAX_COLS - 1; x >= 0; x--) begin
			if (col_fit[x]) begin
				ff_found = 1'b1;
				ff_col   = rffp_pkg::COL_W'(x);
			end
		end
	end

	assign sts.row_oob  = (w_q == '0) || (h_q == '0) ||
		((rffp_pkg::SIZE_W+1)'(y_q) + (rffp_pkg::SIZE_W+1)'(h_q) >
		 (rffp_pkg::SIZE_W+1)'(eff_rows));
	assign sts.last_k   = (k_q + rffp_pkg::SIZE_W'(1)) == h_q;
	assign sts.found    = is_place_q ? col_fit[wc_q] : ff_found;
	assign sts.is_place = is_place_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fabric_cols_q <= rffp_pkg::DIM_W'(rffp_pkg::MAX_COLS);
			fabric_rows_q <= rffp_pkg::DIM_W'(rffp_pkg::MAX_ROWS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rffp_pkg::CFG_FABRIC_COLS: fabric_cols_q <= cfg_data;
				rffp_pkg::CFG_FABRIC_ROWS: fabric_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < rffp_pkg::MAX_ROWS; r++) begin
				occ_q[r] <= '0;
			end
		end else if (cmd.load && s_axis_tdata[0]) begin
			for (int r = 0; r < rffp_pkg::MAX_ROWS; r++) begin
				occ_q[r] <= '0;
			end
		end else if (cmd.mark_step) begin
			occ_q[row_addr[rffp_pkg::ROW_W-1:0]] <= rd_row |
				rffp_pkg::col_span(res_col_q, w_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_place_q <= s_axis_tuser;
			w_q        <= s_axis_tdata[4:1];
			h_q        <= s_axis_tdata[8:5];
			wc_q       <= s_axis_tdata[11:9];
			y_q        <= s_axis_tuser ? rffp_pkg::SIZE_W'(s_axis_tdata[14:12]) : '0;
		end else if (cmd.next_row) begin
			y_q <= y_q + rffp_pkg::SIZE_W'(1);
		end

		if (cmd.row_begin || cmd.hit) begin
			k_q <= '0;
		end else if (cmd.check_step || cmd.mark_step) begin
			k_q <= k_q + rffp_pkg::SIZE_W'(1);
		end

		if (cmd.check_step) begin
			acc_q <= (k_q == '0) ? rd_row : (acc_q | rd_row);
		end

		if (cmd.hit) begin
			res_col_q <= is_place_q ? wc_q : ff_col;
		end

		if (cmd.set_fail) begin
			res_status_q <= is_place_q ? rffp_pkg::ST_BAD_CORNER : rffp_pkg::ST_NO_FIT;
			res_col_q    <= '0;
			res_row_q    <= '0;
		end else if (cmd.set_ok) begin
			res_status_q <= rffp_pkg::ST_PLACED;
			res_row_q    <= y_q[rffp_pkg::ROW_W-1:0];
		end

		if (cmd.out_load) begin
			out_q <= {res_row_q, res_col_q, res_status_q};
		end
	end

	assign m_axis_tdata = out_q;

endmodule

// ===== src/rffp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rffp_ctrl
// Sequencer of the row scan, the fit test and the marking pass.
// ----------------------------------------------------------------------------
module rffp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  rffp_pkg::dp_status_t sts,
	output rffp_pkg::ctrl_cmd_t  cmd
);

	rffp_pkg::state_t state_q;
	rffp_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rffp_pkg::S_IDLE:  if (s_axis_tvalid) state_d = rffp_pkg::S_ROW;
			rffp_pkg::S_ROW:   state_d = sts.row_oob ? rffp_pkg::S_DONE : rffp_pkg::S_CHECK;
			rffp_pkg::S_CHECK: if (sts.last_k) state_d = rffp_pkg::S_EVAL;
			rffp_pkg::S_EVAL: begin
				if (sts.found) begin
					state_d = rffp_pkg::S_MARK;
				end else if (sts.is_place) begin
					state_d = rffp_pkg::S_DONE;
				end else begin
					state_d = rffp_pkg::S_ROW;
				end
			end
			rffp_pkg::S_MARK:  if (sts.last_k) state_d = rffp_pkg::S_DONE;
			rffp_pkg::S_DONE:  if (out_free) state_d = rffp_pkg::S_IDLE;
			default:           state_d = rffp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rffp_pkg::S_IDLE:  cmd.load = s_axis_tvalid;
			rffp_pkg::S_ROW: begin
				cmd.row_begin = 1'b1;
				cmd.set_fail  = sts.row_oob;
			end
			rffp_pkg::S_CHECK: cmd.check_step = 1'b1;
			rffp_pkg::S_EVAL: begin
				cmd.hit      = sts.found;
				cmd.set_fail = !sts.found && sts.is_place;
				cmd.next_row = !sts.found && !sts.is_place;
			end
			rffp_pkg::S_MARK: begin
				cmd.mark_step = 1'b1;
				cmd.set_ok    = sts.last_k;
			end
			rffp_pkg::S_DONE:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rffp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_axis_tready = (state_q == rffp_pkg::S_IDLE);
	assign m_axis_tvalid = out_valid_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit rectangle placer.
// ----------------------------------------------------------------------------
// Requests are streamed in from a queue. A clocked driver and a clocked
// monitor sit on the two stream ports, and both sides insert random gaps.
// A bench-side model of the occupancy bitmap predicts each result word when
// its request is accepted. The monitor compares every result word, field by
// field, with the oldest prediction. Fabric size registers are rewritten only
// between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb;
	import rffp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int IDLE_SETTLE    = 8;
	localparam int TAIL_CYCLES    = 100;
	localparam int RANDOM_PHASES  = 15;
	localparam int PHASE_WORDS    = 95;

	// Spare register indexes beyond the two fabric size registers.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef enum logic {
		REQ_FIRST_FIT = 1'b0,
		REQ_AT_CORNER = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t             kind;
		logic                  clear;
		logic [SIZE_W-1:0]     width;
		logic [SIZE_W-1:0]     height;
		logic [COL_W-1:0]      col;
		logic [ROW_W-1:0]      row;
	} request_t;

	typedef struct packed {
		status_t               status;
		logic [COL_W-1:0]      col;
		logic [ROW_W-1:0]      row;
	} placement_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [DIM_W-1:0]      cfg_data = '0;

	rect_first_fit_placer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// Bench copy of the block state: fabric size registers and the bitmap.
	logic [DIM_W-1:0]     fab_cols = 4'd8;
	logic [DIM_W-1:0]     fab_rows = 4'd8;
	logic [MAX_COLS-1:0]  occ_rows [MAX_ROWS];

	request_t    requests_todo [$];
	placement_t  placements_due [$];
	request_t    cur_req;
	logic        req_taken = 1'b0;
	int          n_fail = 0;

	// Stimulus shaping shared between the sequencer and the two stream sides.
	logic        burst_src = 1'b0;
	logic        hold_rx = 1'b0;
	logic        rx_hold_done = 1'b0;
	int          src_gap = 0;
	int          src_quiet = 0;
	int          rx_stall = 0;
	int          rx_quiet = 0;

	// Register values above the maximum behave as the maximum.
	function automatic int fabric_span(input logic [DIM_W-1:0] v, input int lim);
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	// True when a w-by-h rectangle at (x, y) lies inside the fabric and
	// covers no used tile. Zero-sized rectangles never fit.
	function automatic logic tiles_free(input int x, input int y, input int w, input int h);
		logic [MAX_COLS-1:0] span;
		int r;
		if (w == 0 || h == 0)
			return 1'b0;
		if (x + w > fabric_span(fab_cols, MAX_COLS) || y + h > fabric_span(fab_rows, MAX_ROWS))
			return 1'b0;
		span = MAX_COLS'(((1 << w) - 1) << x);
		for (r = y; r < y + h; r++)
			if ((occ_rows[r] & span) != '0)
				return 1'b0;
		return 1'b1;
	endfunction

	// Applies one request to the bench bitmap and returns the result word
	// the block should give for it.
	function automatic placement_t place_request(input request_t q);
		placement_t res;
		logic [MAX_COLS-1:0] span;
		logic hit;
		int x, y, r, bx, by;
		res.status = ST_NO_FIT;
		res.col = '0;
		res.row = '0;
		hit = 1'b0;
		bx = 0;
		by = 0;
		// A clear stands even when the request then fails.
		if (q.clear)
			for (r = 0; r < MAX_ROWS; r++)
				occ_rows[r] = '0;
		if (q.kind == REQ_AT_CORNER) begin
			if (tiles_free(q.col, q.row, q.width, q.height)) begin
				hit = 1'b1;
				bx = q.col;
				by = q.row;
			end else
				res.status = ST_BAD_CORNER;
		end else begin
			// Row-major scan; the corner fields play no part here.
			for (y = 0; y < fabric_span(fab_rows, MAX_ROWS) && !hit; y++)
				for (x = 0; x < fabric_span(fab_cols, MAX_COLS) && !hit; x++)
					if (tiles_free(x, y, q.width, q.height)) begin
						hit = 1'b1;
						bx = x;
						by = y;
					end
		end
		if (hit) begin
			span = MAX_COLS'(((1 << int'(q.width)) - 1) << bx);
			for (r = by; r < by + int'(q.height); r++)
				occ_rows[r] = occ_rows[r] | span;
			res.status = ST_PLACED;
			res.col = COL_W'(bx);
			res.row = ROW_W'(by);
		end
		return res;
	endfunction

	initial
		for (int r = 0; r < MAX_ROWS; r++)
			occ_rows[r] = '0;

	// Request side. A word is accepted when tvalid and tready are both high
	// at a rising edge; the prediction is made at that same edge.
	always @(posedge clk) begin
		req_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (req_taken)
			placements_due = {placements_due, place_request(cur_req)};
	end

	// Driver: changes the request port only at falling edges. A word that has
	// not been taken is held; otherwise a gap may follow before the next one.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || req_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (requests_todo.size() != 0) begin
				cur_req = requests_todo.pop_front();
				s_axis_tuser <= cur_req.kind;
				s_axis_tdata <= {1'b0, cur_req.row, cur_req.col, cur_req.height,
				                 cur_req.width, cur_req.clear};
				s_axis_tvalid <= 1'b1;
				// Gap before the next word: mostly none or short, a few long,
				// and now and then a stretch with no gaps at all.
				if (burst_src)
					src_gap = 0;
				else if (src_quiet > 0) begin
					src_quiet--;
					src_gap = 0;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:0]:   src_quiet = 50;
						[1:54]:  src_gap = 0;
						[55:89]: src_gap = $urandom_range(1, 3);
						default: src_gap = $urandom_range(8, 40);
					endcase
				end
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: tready is also changed at falling edges only. The one long
	// hold that the sequencer asks for is counted here, in cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_rx && !rx_hold_done) begin
				rx_stall = RX_HOLD_CYCLES;
				rx_hold_done = 1'b1;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_quiet > 0)
					rx_quiet--;
				else begin
					case ($urandom_range(0, 199)) inside
						[0:1]:     rx_quiet = 150;
						[2:139]:   rx_stall = 0;
						[140:189]: rx_stall = $urandom_range(1, 4);
						default:   rx_stall = $urandom_range(10, 60);
					endcase
				end
				m_axis_tready <= (rx_stall == 0);
			end
		end
	end

	// Monitor: every accepted result word is matched to the oldest prediction.
	always @(posedge clk) begin : result_check
		placement_t want;
		logic [1:0] got_status;
		logic [COL_W-1:0] got_col;
		logic [ROW_W-1:0] got_row;
		got_status = m_axis_tdata[1:0];
		got_col = m_axis_tdata[4:2];
		got_row = m_axis_tdata[7:5];
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (placements_due.size() == 0) begin
				$error("result word %h arrived with no request outstanding", m_axis_tdata);
				n_fail++;
			end else begin
				want = placements_due.pop_front();
				if (got_status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got_status);
					n_fail++;
				end
				if (got_col !== want.col) begin
					$error("place_col: expected %0d, actual %0d", want.col, got_col);
					n_fail++;
				end
				if (got_row !== want.row) begin
					$error("place_row: expected %0d, actual %0d", want.row, got_row);
					n_fail++;
				end
			end
		end
	end

	// Watchdog: a run of cycles in which no word moves on any port means the
	// block has hung.
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// One register write; the bench copy follows at the accepting edge.
	// Indexes beyond the two registers must leave the fabric size alone.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_FABRIC_COLS)
			fab_cols = val;
		else if (idx == CFG_FABRIC_ROWS)
			fab_rows = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_fabric(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
		write_reg(CFG_FABRIC_COLS, cols);
		write_reg(CFG_FABRIC_ROWS, rows);
	endtask

	// Waits until every request has been sent and answered, then lets the block
	// settle so that it is surely idle before the next register write.
	task automatic wait_idle();
		@(posedge clk);
		while (requests_todo.size() != 0 || s_axis_tvalid || placements_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic add(input req_kind_t kind, input logic clear,
			input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
		request_t q;
		q.kind = kind;
		q.clear = clear;
		q.width = w;
		q.height = h;
		q.col = col;
		q.row = row;
		requests_todo = {requests_todo, q};
	endtask

	// Random requests shaped to the current fabric: mostly sizes that can
	// fit, biased small so the bitmap fills gradually, with an occasional
	// clear, plus some out-of-range sizes and corners as noise.
	task automatic add_random(input int n);
		request_t q;
		int lim_c, lim_r;
		lim_c = fabric_span(fab_cols, MAX_COLS);
		lim_r = fabric_span(fab_rows, MAX_ROWS);
		if (lim_c == 0)
			lim_c = MAX_COLS;
		if (lim_r == 0)
			lim_r = MAX_ROWS;
		repeat (n) begin
			q.kind = ($urandom_range(0, 99) < 55) ? REQ_FIRST_FIT : REQ_AT_CORNER;
			q.clear = ($urandom_range(0, 99) < 6);
			if ($urandom_range(0, 99) < 85) begin
				q.width = SIZE_W'($urandom_range(1, $urandom_range(1, lim_c)));
				q.height = SIZE_W'($urandom_range(1, $urandom_range(1, lim_r)));
			end else begin
				q.width = SIZE_W'($urandom_range(0, 15));
				q.height = SIZE_W'($urandom_range(0, 15));
			end
			if (q.kind == REQ_AT_CORNER && $urandom_range(0, 99) < 80) begin
				q.col = COL_W'($urandom_range(0, lim_c - 1));
				q.row = ROW_W'($urandom_range(0, lim_r - 1));
			end else begin
				q.col = COL_W'($urandom_range(0, MAX_COLS - 1));
				q.row = ROW_W'($urandom_range(0, MAX_ROWS - 1));
			end
			requests_todo = {requests_todo, q};
		end
	endtask

	initial begin : sequencer
		logic [DIM_W-1:0] phase_cols [RANDOM_PHASES];
		logic [DIM_W-1:0] phase_rows [RANDOM_PHASES];
		phase_cols = '{8, 1, 8, 1, 4, 15, 0, 6, 8, 2, 7, 8, 0, 0, 0};
		phase_rows = '{8, 1, 1, 8, 4, 12, 5, 3, 0, 8, 6, 8, 0, 0, 0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset-size fabric: full fill, rejects for a
		// used corner, zero-sized and oversized rectangles, corners off the
		// edge, a clear that stands although its request fails, and corner
		// fields that first fit must ignore.
		add(REQ_FIRST_FIT, 1, 8, 8, 0, 0);
		add(REQ_FIRST_FIT, 0, 1, 1, 5, 3);
		add(REQ_AT_CORNER, 0, 1, 1, 7, 7);
		add(REQ_AT_CORNER, 1, 1, 1, 7, 7);
		add(REQ_FIRST_FIT, 0, 0, 3, 0, 0);
		add(REQ_AT_CORNER, 0, 2, 0, 0, 0);
		add(REQ_FIRST_FIT, 0, 9, 1, 0, 0);
		add(REQ_AT_CORNER, 0, 15, 15, 0, 0);
		add(REQ_AT_CORNER, 0, 2, 1, 7, 0);
		add(REQ_FIRST_FIT, 0, 3, 2, 7, 7);
		add(REQ_FIRST_FIT, 0, 3, 2, 0, 0);
		add(REQ_FIRST_FIT, 0, 8, 1, 0, 0);
		add(REQ_FIRST_FIT, 1, 0, 0, 0, 0);
		add(REQ_FIRST_FIT, 0, 8, 8, 0, 0);
		add(REQ_AT_CORNER, 1, 4, 4, 4, 4);
		wait_idle();

		// Shrink the fabric: tiles outside keep their bits but are not seen.
		set_fabric(4, 4);
		add(REQ_FIRST_FIT, 0, 4, 4, 0, 0);
		add(REQ_FIRST_FIT, 0, 1, 1, 0, 0);
		wait_idle();
		// Grow it back: the old upper-right block is still in use.
		set_fabric(8, 8);
		add(REQ_AT_CORNER, 0, 1, 1, 5, 5);
		add(REQ_FIRST_FIT, 0, 1, 1, 0, 0);
		wait_idle();

		// A fabric with no tiles, first with no columns, then with no rows.
		set_fabric(0, 8);
		add(REQ_FIRST_FIT, 0, 1, 1, 0, 0);
		add(REQ_AT_CORNER, 0, 1, 1, 0, 0);
		wait_idle();
		set_fabric(8, 0);
		add(REQ_FIRST_FIT, 0, 1, 1, 0, 0);
		add(REQ_AT_CORNER, 0, 1, 1, 0, 0);
		wait_idle();

		// Sizes above the maximum act as the maximum, and writes to the
		// spare indexes change nothing.
		set_fabric(15, 12);
		write_reg(CFG_SPARE_LO, 3);
		write_reg(CFG_SPARE_HI, 1);
		add(REQ_FIRST_FIT, 1, 8, 8, 0, 0);
		add(REQ_AT_CORNER, 1, 8, 8, 0, 0);
		wait_idle();

		// Random phases, each on its own fabric size. In the first one the
		// sender runs without gaps while the receiver holds off for a long
		// stretch, so the block fills and has to stall its request port.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p >= RANDOM_PHASES - 3)
				set_fabric(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)));
			else
				set_fabric(phase_cols[p], phase_rows[p]);
			if (p == 0) begin
				burst_src = 1'b1;
				hold_rx = 1'b1;
			end
			add_random(PHASE_WORDS);
			wait_idle();
			burst_src = 1'b0;
		end

		// Any late or extra result word would show up in this window.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== rect_first_fit_placer.f =====
src/rffp_pkg.sv
src/rffp_datapath.sv
src/rffp_ctrl.sv
src/rect_first_fit_placer.sv
tb/tb.sv
